// ----- design/skri_pkg.sv -----
// Shared types and constants for the sorted key record index.
// Used by skri_table, skri_ctrl, sorted_key_record_index and skri_check.
`default_nettype none

package skri_pkg;

    // Table size and derived widths.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Request codes.
    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_FIND    = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_RD_HDL  = 3'd3;
    localparam logic [2:0] REQ_RD_CLI  = 3'd4;
    localparam logic [2:0] REQ_WR_CLI  = 3'd5;
    localparam logic [2:0] REQ_CLEAR   = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One table entry as stored in memory.
    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] handle;
        logic        [31:0] client;
    } entry_t;

    // Memory access request from the sequencer to the table.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    // One finished result.
    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      handle;
        logic [31:0]      client;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

// ----- design/sorted_key_record_index.sv -----
// Top level of the sorted key record index: sequencer, entry store and
// output register. Depends on skri_pkg, skri_ctrl and skri_table.
//
//   Channel | Valid     | Ready     | Payload
//   --------+-----------+-----------+------------------------------------------------
//   request | in_valid  | in_ready  | req_type, key, record_handle, position, client_word
//   result  | out_valid | out_ready | status, found_handle, found_client, entry_count
//
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle. Find, add and remove run a binary search of P probes
// (at most 11 at 1024 entries), one probe per cycle through the shared key
// comparisons; add, and remove on a hit, then move the entries behind the
// slot one slot, one read and one write per cycle. Reads by position and client
// writes pass the positional read state; an out-of-range position, clear, no-op
// and a full-table add go straight to done. After reset the table is empty and
// the first request may follow at once. A result waits in the output register;
// the sequencer holds its next result while that one stalls.
`default_nettype none

module sorted_key_record_index (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [2:0]                   req_type,
    input  wire logic signed [31:0]           key,
    input  wire logic [31:0]                  record_handle,
    input  wire logic [skri_pkg::ADDR_W-1:0]  position,
    input  wire logic [31:0]                  client_word,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        status,
    output logic [31:0]                       found_handle,
    output logic [31:0]                       found_client,
    output logic [skri_pkg::CNT_W-1:0]        entry_count
);

    skri_pkg::mem_req_t  mem_req;
    skri_pkg::entry_t    rd_data;
    skri_pkg::result_t   res;
    logic                res_valid;
    logic                res_take;

    logic                out_valid_reg, out_valid_next;
    skri_pkg::result_t   out_res_reg;

    skri_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .key           (key),
        .record_handle (record_handle),
        .position      (position),
        .client_word   (client_word),
        .mem_req       (mem_req),
        .rd_data       (rd_data),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    skri_table u_table (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Result moves into the output register when it is empty or draining.
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign found_handle = out_res_reg.handle;
    assign found_client = out_res_reg.client;
    assign entry_count  = out_res_reg.count;

endmodule

`default_nettype wire

// ----- design/skri_table.sv -----
// Entry store: one write port and one read port with registered read data.
// Depends on skri_pkg for the entry and request types.
`default_nettype none

module skri_table (
    input  wire logic              clk,
    input  wire skri_pkg::mem_req_t mem_req,
    output skri_pkg::entry_t       rd_data
);

    skri_pkg::entry_t entry_mem [skri_pkg::TABLE_DEPTH];
    skri_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= entry_mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/skri_ctrl.sv -----
// Request sequencer: binary search with one shared key compare per cycle,
// streamed entry moves for insert and remove, and positional access.
// Depends on skri_pkg; drives the skri_table memory port.
`default_nettype none

module skri_ctrl (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [2:0]                           req_type,
    input  wire logic signed [31:0]                   key,
    input  wire logic [31:0]                          record_handle,
    input  wire logic [skri_pkg::ADDR_W-1:0]          position,
    input  wire logic [31:0]                          client_word,
    output skri_pkg::mem_req_t                        mem_req,
    input  wire skri_pkg::entry_t                     rd_data,
    output logic                                      res_valid,
    output skri_pkg::result_t                         res,
    input  wire logic                                 res_take
);

    localparam int AW = skri_pkg::ADDR_W;
    localparam int CW = skri_pkg::CNT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_WRNEW = 3'd3;
    localparam logic [2:0] S_POS   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [CW-1:0]     count_reg,   count_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [2:0]        req_reg,     req_next;
    logic signed [31:0] key_reg,    key_next;
    logic [31:0]       handle_reg,  handle_next;
    logic [AW-1:0]     pos_reg,     pos_next;
    logic [31:0]       client_reg,  client_next;
    logic [CW-1:0]     lo_reg,      lo_next;
    logic [CW-1:0]     hi_reg,      hi_next;
    logic [AW-1:0]     mid_reg,     mid_next;
    logic [AW-1:0]     slot_reg,    slot_next;
    logic [CW-1:0]     mv_src_reg,  mv_src_next;
    logic [CW-1:0]     mv_left_reg, mv_left_next;
    logic              mv_down_reg, mv_down_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [1:0]        status_reg,  status_next;
    logic [31:0]       rh_reg,      rh_next;
    logic [31:0]       rc_reg,      rc_next;

    // Search bound update, evaluated after each compare or at request start.
    logic              srch_eval;
    logic              srch_add;
    logic [CW-1:0]     srch_lo;
    logic [CW-1:0]     srch_hi;
    logic [CW:0]       mid_sum;
    logic              key_lt;
    logic              key_gt;

    // The shared signed key comparisons, one in each direction.
    assign key_lt = key_reg < rd_data.key;
    assign key_gt = rd_data.key < key_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.handle = rh_reg;
    assign res.client = rc_reg;
    assign res.count  = count_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        wr_pend_next = 1'b0;
        req_next     = req_reg;
        key_next     = key_reg;
        handle_next  = handle_reg;
        pos_next     = pos_reg;
        client_next  = client_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        slot_next    = slot_reg;
        mv_src_next  = mv_src_reg;
        mv_left_next = mv_left_reg;
        mv_down_next = mv_down_reg;
        wr_addr_next = wr_addr_reg;
        status_next  = status_reg;
        rh_next      = rh_reg;
        rc_next      = rc_reg;
        mem_req      = '0;
        srch_eval    = 1'b0;
        srch_add     = 1'b0;
        srch_lo      = lo_reg;
        srch_hi      = hi_reg;
        mid_sum      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = req_type;
                    key_next    = key;
                    handle_next = record_handle;
                    pos_next    = position;
                    client_next = client_word;
                    status_next = skri_pkg::ST_OK;
                    rh_next     = '0;
                    rc_next     = '0;
                    unique case (req_type) inside
                        skri_pkg::REQ_ADD:
                        begin
                            if (count_reg == CW'(skri_pkg::TABLE_DEPTH))
                            begin
                                status_next = skri_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                srch_eval = 1'b1;
                                srch_add  = 1'b1;
                                srch_lo   = '0;
                                srch_hi   = count_reg;
                            end
                        end
                        skri_pkg::REQ_FIND, skri_pkg::REQ_REMOVE:
                        begin
                            srch_eval = 1'b1;
                            srch_lo   = '0;
                            srch_hi   = count_reg;
                        end
                        skri_pkg::REQ_RD_HDL, skri_pkg::REQ_RD_CLI, skri_pkg::REQ_WR_CLI:
                        begin
                            if ({1'b0, position} >= count_reg)
                            begin
                                status_next = skri_pkg::ST_MISS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = position;
                                state_next      = S_POS;
                            end
                        end
                        skri_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Probe data is back: narrow the bounds or take the hit.
            S_CMP:
            begin
                if (req_reg == skri_pkg::REQ_ADD)
                begin
                    srch_eval = 1'b1;
                    srch_add  = 1'b1;
                    if (key_lt)
                    begin
                        srch_hi = {1'b0, mid_reg};
                    end
                    else
                    begin
                        srch_lo = {1'b0, mid_reg} + CW'(1);
                    end
                end
                else if (key_gt)
                begin
                    srch_eval = 1'b1;
                    srch_lo   = {1'b0, mid_reg} + CW'(1);
                end
                else if (key_lt)
                begin
                    srch_eval = 1'b1;
                    srch_hi   = {1'b0, mid_reg};
                end
                else
                begin
                    rh_next = rd_data.handle;
                    rc_next = rd_data.client;
                    if (req_reg == skri_pkg::REQ_REMOVE)
                    begin
                        mv_left_next = count_reg - {1'b0, mid_reg} - CW'(1);
                        mv_src_next  = {1'b0, mid_reg} + CW'(1);
                        mv_down_next = 1'b0;
                        state_next   = S_MOVE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // Stream entries one slot up or down: read one, write the previous.
            S_MOVE:
            begin
                if (mv_left_reg != '0)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mv_src_reg[AW-1:0];
                    wr_pend_next    = 1'b1;
                    mv_left_next    = mv_left_reg - CW'(1);
                    if (mv_down_reg)
                    begin
                        wr_addr_next = AW'(mv_src_reg + CW'(1));
                        mv_src_next  = mv_src_reg - CW'(1);
                    end
                    else
                    begin
                        wr_addr_next = AW'(mv_src_reg - CW'(1));
                        mv_src_next  = mv_src_reg + CW'(1);
                    end
                end
                if (wr_pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = wr_addr_reg;
                    mem_req.wr_data = rd_data;
                end
                if ((mv_left_reg == '0) && !wr_pend_reg)
                begin
                    if (req_reg == skri_pkg::REQ_ADD)
                    begin
                        state_next = S_WRNEW;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            // Drop the new entry into the opened slot.
            S_WRNEW:
            begin
                mem_req.wr_en          = 1'b1;
                mem_req.wr_addr        = slot_reg;
                mem_req.wr_data.key    = key_reg;
                mem_req.wr_data.handle = handle_reg;
                mem_req.wr_data.client = '0;
                count_next             = count_reg + CW'(1);
                rh_next                = handle_reg;
                state_next             = S_DONE;
            end

            // Positional read, with write-back for a client update.
            S_POS:
            begin
                rh_next = rd_data.handle;
                if (req_reg == skri_pkg::REQ_WR_CLI)
                begin
                    rc_next                = client_reg;
                    mem_req.wr_en          = 1'b1;
                    mem_req.wr_addr        = pos_reg;
                    mem_req.wr_data.key    = rd_data.key;
                    mem_req.wr_data.handle = rd_data.handle;
                    mem_req.wr_data.client = client_reg;
                end
                else
                begin
                    rc_next = rd_data.client;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Next probe issues straight from the updated bounds; an empty
        // range ends the search as a miss or as the insert slot.
        if (srch_eval)
        begin
            lo_next = srch_lo;
            hi_next = srch_hi;
            if (srch_lo < srch_hi)
            begin
                if (srch_add)
                begin
                    mid_sum = {1'b0, srch_lo} + {1'b0, srch_hi};
                end
                else
                begin
                    mid_sum = {1'b0, srch_lo} + {1'b0, srch_hi} - (CW + 1)'(1);
                end
                mid_next        = mid_sum[AW:1];
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = mid_sum[AW:1];
                state_next      = S_CMP;
            end
            else if (srch_add)
            begin
                slot_next    = srch_lo[AW-1:0];
                mv_left_next = count_reg - srch_lo;
                mv_src_next  = count_reg - CW'(1);
                mv_down_next = 1'b1;
                state_next   = S_MOVE;
            end
            else
            begin
                status_next = skri_pkg::ST_MISS;
                state_next  = S_DONE;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    // Request and working registers.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        handle_reg  <= handle_next;
        pos_reg     <= pos_next;
        client_reg  <= client_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        slot_reg    <= slot_next;
        mv_src_reg  <= mv_src_next;
        mv_left_reg <= mv_left_next;
        mv_down_reg <= mv_down_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        rh_reg      <= rh_next;
        rc_reg      <= rc_next;
    end

endmodule

`default_nettype wire

// ----- design/skri_check.sv -----
// Port-level checker for sorted_key_record_index, bound to the top level.
// Depends on skri_pkg for status codes and the table depth.
`default_nettype none

module skri_check (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [1:0]                   status,
    input wire logic [31:0]                  found_handle,
    input wire logic [31:0]                  found_client,
    input wire logic [skri_pkg::CNT_W-1:0]   entry_count
);

    // A request transfer always starts work, so ready drops right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready held after a request transfer");

    // A stalled result transfer keeps its valid and payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(found_handle) && $stable(found_client) && $stable(entry_count))
    else $error("result changed while stalled");

    // The reported count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= skri_pkg::CNT_W'(skri_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

    // A full-table result only comes with a full table and no entry data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == skri_pkg::ST_FULL |->
            entry_count == skri_pkg::CNT_W'(skri_pkg::TABLE_DEPTH)
            && found_handle == '0 && found_client == '0)
    else $error("bad full-table result");

    // A miss reports no entry data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == skri_pkg::ST_MISS |-> found_handle == '0 && found_client == '0)
    else $error("miss result carries entry data");

endmodule

bind sorted_key_record_index skri_check u_skri_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_handle (found_handle),
    .found_client (found_client),
    .entry_count  (entry_count)
);

`default_nettype wire
